// ----- rtl/core/csa_pkg.sv -----
// csa_pkg: shared types and codes for the contiguous segment allocator
// no dependencies; used by csa_table and contiguous_segment_allocator_top
`default_nettype none

package csa_pkg;

    localparam int unsigned ADDR_W = 16;
    localparam int unsigned ID_W   = 8;

    typedef enum logic [1:0] {
        OP_FIRST_FIT = 2'd0,
        OP_WORST_FIT = 2'd1,
        OP_REMOVE    = 2'd2,
        OP_COMPACT   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOSPACE  = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  process_id;
        logic [15:0] request_size;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  owner_id;
        logic [15:0] location;
        logic        last;
    } resp_t;

    typedef struct packed {
        logic [15:0] base;
        logic [15:0] length;
        logic [7:0]  owner;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE,
        S_COMPACT
    } state_t;

endpackage : csa_pkg

`default_nettype wire

// ----- rtl/core/csa_table.sv -----
// csa_table: segment table memory, one write port and one registered read port
// depends on csa_pkg
`default_nettype none

module csa_table #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned IDX_W = 4
) (
    input  wire logic                clk,
    input  wire logic                we,
    input  wire logic [IDX_W-1:0]    waddr,
    input  wire csa_pkg::entry_t     wdata,
    input  wire logic [IDX_W-1:0]    raddr,
    output csa_pkg::entry_t          rdata
);

    csa_pkg::entry_t mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule : csa_table

`default_nettype wire

// ----- rtl/core/contiguous_segment_allocator_top.sv -----
// contiguous_segment_allocator_top: request sequencer around the segment table
// depends on csa_pkg and csa_table
`default_nettype none

// Segment allocator over a managed space whose size is set by the configuration
// register. The table is kept in address order in a memory with one registered
// read port. busy is high from the accepting edge of start until the cycle of
// the last result beat, inclusive. A request reads the table one entry at a
// time, waiting on each registered read before it evaluates that entry. An
// allocation walks its holes; if one fits, it moves the entries above that hole
// up one slot each and writes the new entry into the opened slot. It ends by
// registering the result and giving the beat. A remove walks to the matching
// entry, then moves the entries above it down one slot each. A compact gives
// one beat per segment, or a single beat for an empty table. A compact of an
// empty table and an allocation into a full table go straight to the result.
// An allocation runs longest for a worst fit below every entry. The receiver
// cannot stall result beats. There is no clearing pass after reset.
module contiguous_segment_allocator_top #(
    parameter int unsigned MAX_SEGMENTS = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire csa_pkg::req_t   request,
    output logic                 busy,
    output logic                 result_valid,
    output csa_pkg::resp_t       result,
    input  wire logic            cfg_we,
    input  wire logic [15:0]     cfg_wdata
);

    localparam int unsigned IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);

    csa_pkg::state_t state_reg, state_next;
    logic [15:0]      space_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             phase_reg, phase_next;
    logic [1:0]       op_reg, op_next;
    logic [7:0]       id_reg, id_next;
    logic [15:0]      size_reg, size_next;
    logic [15:0]      prev_end_reg, prev_end_next;
    logic             found_reg, found_next;
    logic [CNT_W-1:0] pick_reg, pick_next;
    logic [15:0]      best_reg, best_next;
    logic [15:0]      pbase_reg, pbase_next;
    logic [2:0]       st_reg, st_next;
    logic             rv_reg, rv_next;
    csa_pkg::resp_t   res_reg, res_next;
    logic             accept;

    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    csa_pkg::entry_t  wdata, rdata;

    csa_table #(.DEPTH(MAX_SEGMENTS), .IDX_W(IDX_W)) u_table (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // hole ending at the entry just read, or at the space size for the tail
    logic [15:0] hole_top, hole_sz;
    logic        at_tail;
    always_comb
    begin
        at_tail  = (k_reg == count_reg);
        hole_top = at_tail ? space_reg : rdata.base;
        hole_sz  = (hole_top > prev_end_reg) ? (hole_top - prev_end_reg) : 16'd0;
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            space_reg <= 16'd4096;
        end
        else if (cfg_we)
        begin
            space_reg <= cfg_wdata;
        end
    end

    // control and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csa_pkg::S_IDLE;
            count_reg <= '0;
            rv_reg    <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rv_reg    <= rv_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        op_reg       <= op_next;
        id_reg       <= id_next;
        size_reg     <= size_next;
        prev_end_reg <= prev_end_next;
        found_reg    <= found_next;
        pick_reg     <= pick_next;
        best_reg     <= best_next;
        pbase_reg    <= pbase_next;
        st_reg       <= st_next;
        res_reg      <= res_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            csa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (request.operation == csa_pkg::OP_COMPACT)
                    begin
                        state_next = (count_reg == '0) ? csa_pkg::S_DONE
                                                       : csa_pkg::S_COMPACT;
                    end
                    else if (request.operation != csa_pkg::OP_REMOVE &&
                             count_reg >= CNT_W'(MAX_SEGMENTS))
                    begin
                        state_next = csa_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = csa_pkg::S_SCAN;
                    end
                end
            end
            csa_pkg::S_SCAN:
            begin
                if (phase_reg)
                begin
                    if (op_reg == csa_pkg::OP_REMOVE)
                    begin
                        if (at_tail)
                            state_next = csa_pkg::S_DONE;
                        else if (rdata.owner == id_reg)
                            state_next = csa_pkg::S_SHIFT;
                    end
                    else if (at_tail ||
                             (op_reg == csa_pkg::OP_FIRST_FIT &&
                              size_reg != 16'd0 && hole_sz >= size_reg))
                    begin
                        state_next = csa_pkg::S_SHIFT;
                    end
                end
            end
            csa_pkg::S_SHIFT:
            begin
                if (!found_reg)
                    state_next = csa_pkg::S_DONE;
                else if (op_reg == csa_pkg::OP_REMOVE)
                begin
                    if (k_reg + CNT_W'(1) >= count_reg)
                        state_next = csa_pkg::S_DONE;
                end
                else if (k_reg <= pick_reg)
                    state_next = csa_pkg::S_DONE;
            end
            csa_pkg::S_DONE:
                state_next = csa_pkg::S_IDLE;
            csa_pkg::S_COMPACT:
            begin
                if (phase_reg && k_reg + CNT_W'(1) == count_reg)
                    state_next = csa_pkg::S_IDLE;
            end
            default:
                state_next = csa_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next    = count_reg;
        k_next        = k_reg;
        phase_next    = 1'b0;
        op_next       = op_reg;
        id_next       = id_reg;
        size_next     = size_reg;
        prev_end_next = prev_end_reg;
        found_next    = found_reg;
        pick_next     = pick_reg;
        best_next     = best_reg;
        pbase_next    = pbase_reg;
        st_next       = st_reg;
        rv_next       = 1'b0;
        res_next      = res_reg;
        we            = 1'b0;
        waddr         = k_reg[IDX_W-1:0];
        wdata         = rdata;
        raddr         = k_reg[IDX_W-1:0];
        case (state_reg)
            csa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next       = request.operation;
                    id_next       = request.process_id;
                    size_next     = request.request_size;
                    k_next        = '0;
                    raddr         = '0;
                    prev_end_next = 16'd0;
                    found_next    = 1'b0;
                    best_next     = 16'd0;
                    pick_next     = '0;
                    pbase_next    = 16'd0;
                    if (request.operation == csa_pkg::OP_COMPACT)
                        st_next = csa_pkg::ST_EMPTY;
                    else if (request.operation == csa_pkg::OP_REMOVE)
                        st_next = csa_pkg::ST_NOTFOUND;
                    else if (count_reg >= CNT_W'(MAX_SEGMENTS))
                        st_next = csa_pkg::ST_FULL;
                    else
                        st_next = csa_pkg::ST_NOSPACE;
                end
            end
            csa_pkg::S_SCAN:
            begin
                // phase 0 waits on the read, phase 1 evaluates one hole/entry
                phase_next = ~phase_reg;
                if (phase_reg)
                begin
                    if (op_reg == csa_pkg::OP_REMOVE)
                    begin
                        if (!at_tail && rdata.owner == id_reg)
                        begin
                            found_next = 1'b1;
                            pbase_next = rdata.base;
                            st_next    = csa_pkg::ST_OK;
                            k_next     = k_reg;
                            raddr      = k_reg[IDX_W-1:0] + IDX_W'(1);
                        end
                        else
                        begin
                            k_next = k_reg + CNT_W'(1);
                            raddr  = k_next[IDX_W-1:0];
                        end
                    end
                    else
                    begin
                        if (size_reg != 16'd0 && hole_sz >= size_reg &&
                            (!found_reg || op_reg == csa_pkg::OP_FIRST_FIT ||
                             hole_sz > best_reg))
                        begin
                            found_next = 1'b1;
                            best_next  = hole_sz;
                            pick_next  = k_reg;
                            pbase_next = prev_end_reg;
                            st_next    = csa_pkg::ST_OK;
                        end
                        prev_end_next = rdata.base + rdata.length;
                        if (state_next == csa_pkg::S_SHIFT)
                        begin
                            // start moving up from the top entry
                            k_next = count_reg;
                            raddr  = k_next[IDX_W-1:0] - IDX_W'(1);
                        end
                        else
                        begin
                            k_next = k_reg + CNT_W'(1);
                            raddr  = k_next[IDX_W-1:0];
                        end
                    end
                end
                else
                begin
                    raddr = k_reg[IDX_W-1:0];
                end
            end
            csa_pkg::S_SHIFT:
            begin
                phase_next = ~phase_reg;
                if (!found_reg)
                begin
                    phase_next = 1'b0;
                end
                else if (op_reg == csa_pkg::OP_REMOVE)
                begin
                    raddr = k_reg[IDX_W-1:0] + IDX_W'(1);
                    if (k_reg + CNT_W'(1) >= count_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        phase_next = 1'b0;
                    end
                    else if (phase_reg)
                    begin
                        // entry k+1 moves down to k
                        we     = 1'b1;
                        waddr  = k_reg[IDX_W-1:0];
                        k_next = k_reg + CNT_W'(1);
                        raddr  = k_next[IDX_W-1:0] + IDX_W'(1);
                    end
                end
                else
                begin
                    raddr = k_reg[IDX_W-1:0] - IDX_W'(1);
                    if (k_reg <= pick_reg)
                    begin
                        // new entry lands in the opened slot
                        we          = 1'b1;
                        waddr       = pick_reg[IDX_W-1:0];
                        wdata.base  = pbase_reg;
                        wdata.length = size_reg;
                        wdata.owner = id_reg;
                        count_next  = count_reg + CNT_W'(1);
                        phase_next  = 1'b0;
                    end
                    else if (phase_reg)
                    begin
                        // entry k-1 moves up to k
                        we     = 1'b1;
                        waddr  = k_reg[IDX_W-1:0];
                        k_next = k_reg - CNT_W'(1);
                        raddr  = k_next[IDX_W-1:0] - IDX_W'(1);
                    end
                end
            end
            csa_pkg::S_DONE:
            begin
                rv_next           = 1'b1;
                res_next.status   = st_reg;
                res_next.owner_id = (op_reg == csa_pkg::OP_COMPACT) ? 8'd0 : id_reg;
                res_next.location = (st_reg == csa_pkg::ST_OK) ? pbase_reg : 16'd0;
                res_next.last     = 1'b1;
            end
            csa_pkg::S_COMPACT:
            begin
                phase_next = ~phase_reg;
                raddr      = k_reg[IDX_W-1:0];
                if (phase_reg)
                begin
                    we                = 1'b1;
                    waddr             = k_reg[IDX_W-1:0];
                    wdata.base        = prev_end_reg;
                    prev_end_next     = prev_end_reg + rdata.length;
                    rv_next           = 1'b1;
                    res_next.status   = csa_pkg::ST_OK;
                    res_next.owner_id = rdata.owner;
                    res_next.location = prev_end_reg;
                    res_next.last     = (k_reg + CNT_W'(1) == count_reg);
                    k_next            = k_reg + CNT_W'(1);
                    raddr             = k_next[IDX_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign busy         = (state_reg != csa_pkg::S_IDLE) || rv_reg;
    assign accept       = start && !busy;
    assign result_valid = rv_reg;
    assign result       = res_reg;

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SEGMENTS))
        else $error("segment count above table depth");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result beat while not busy");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        (count_reg == $past(count_reg) + CNT_W'(1) ||
         count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("segment count changed by more than one");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |=> !result_valid)
        else $error("beat after last");

endmodule : contiguous_segment_allocator_top

`default_nettype wire
